// ----- hdl/midi_track_event_parser_macros.svh -----
// Assertion macros for the MIDI track event parser.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef MIDI_TRACK_EVENT_PARSER_MACROS_SVH
`define MIDI_TRACK_EVENT_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MTEP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mtep check failed");

// Next-cycle implication, disabled during reset.
`define MTEP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mtep check failed");

`endif

// ----- hdl/mtep_pkg.sv -----
// Shared types, codes and the MIDI data-length table for the track event parser.
// No dependencies; used by every module.
`default_nettype none

package mtep_pkg;

   localparam int MAX_VLQ_BYTES = 4;
   localparam int VLQ_CNT_W     = 3;

   localparam logic [2:0] PH_DELTA     = 3'd0;
   localparam logic [2:0] PH_STATUS    = 3'd1;
   localparam logic [2:0] PH_DATA1     = 3'd2;
   localparam logic [2:0] PH_DATA2     = 3'd3;
   localparam logic [2:0] PH_META_TYPE = 3'd4;
   localparam logic [2:0] PH_META_LEN  = 3'd5;
   localparam logic [2:0] PH_META_DATA = 3'd6;
   localparam logic [2:0] PH_SYSEX     = 3'd7;

   localparam logic [1:0] KIND_MIDI  = 2'd0;
   localparam logic [1:0] KIND_META  = 2'd1;
   localparam logic [1:0] KIND_SYSEX = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   localparam logic [1:0] NEED_BAD = 2'd3;

   localparam logic [7:0] ST_META     = 8'hFF;
   localparam logic [7:0] ST_SYSEX    = 8'hF0;
   localparam logic [7:0] ST_SYSEX_END = 8'hF7;
   localparam logic [7:0] ST_REALTIME = 8'hF8;
   localparam logic [7:0] ST_CHANNEL  = 8'h80;

   typedef struct packed {
      logic       fire;
      logic [7:0] track_byte;
      logic       track_start;
   } step_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [27:0] delta_time;
      logic [7:0]  status_byte;
      logic [1:0]  data_count;
      logic [7:0]  data_one;
      logic [7:0]  data_two;
      logic [7:0]  payload_byte;
      logic        payload_valid;
      logic        last_of_run;
   } rsp_type;

   function automatic logic [1:0] data_need(input logic [7:0] s);
      logic [1:0] n;
      if (!s[7]) begin
         n = NEED_BAD;
      end else if (s[7:4] != 4'hF) begin
         n = (s[7:4] == 4'hC || s[7:4] == 4'hD) ? 2'd1 : 2'd2;
      end else begin
         case (s)
            8'hF1, 8'hF3: n = 2'd1;
            8'hF2:        n = 2'd2;
            8'hF6, 8'hF8, 8'hFA, 8'hFB, 8'hFC, 8'hFE: n = 2'd0;
            default:      n = NEED_BAD;
         endcase
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/mtep_if.sv -----
// Valid/ready channel interfaces for track bytes and parsed results.
// No dependencies; the result field widths are written out here.
`default_nettype none

interface mtep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] track_byte;
   logic       track_start;

   modport source (output valid, output track_byte, output track_start, input ready);
   modport sink   (input valid, input track_byte, input track_start, output ready);
endinterface

interface mtep_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [27:0] delta_time;
   logic [7:0]  status_byte;
   logic [1:0]  data_count;
   logic [7:0]  data_one;
   logic [7:0]  data_two;
   logic [7:0]  payload_byte;
   logic        payload_valid;
   logic        last_of_run;

   modport source (output valid, output kind, output delta_time, output status_byte,
                   output data_count, output data_one, output data_two,
                   output payload_byte, output payload_valid, output last_of_run,
                   input ready);
   modport sink   (input valid, input kind, input delta_time, input status_byte,
                   input data_count, input data_one, input data_two,
                   input payload_byte, input payload_valid, input last_of_run,
                   output ready);
endinterface

`default_nettype wire

// ----- hdl/mtep_input_stage.sv -----
// Input register for track byte beats; it holds while out_free is low.
// Depends on mtep_pkg and mtep_req_if; hands one step per cycle to the decoder.
`default_nettype none

module mtep_input_stage (
   input  wire logic          clock,
   input  wire logic          reset,
   mtep_req_if.sink           req_port,
   input  wire logic          out_free,
   output mtep_pkg::step_type step
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       start_ff;
   logic       advance;
   logic       take;

   assign advance        = valid_ff && out_free;
   assign req_port.ready = !valid_ff || advance;
   assign take           = req_port.valid && req_port.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff  <= req_port.track_byte;
         start_ff <= req_port.track_start;
      end
   end

   assign step.fire        = advance;
   assign step.track_byte  = byte_ff;
   assign step.track_start = start_ff;

endmodule

`default_nettype wire

// ----- hdl/mtep_decoder.sv -----
// Parse state and one-byte decode step: delta time, status, data, meta and sysex.
// Depends on mtep_pkg and the assertion macro header.
`default_nettype none
`include "midi_track_event_parser_macros.svh"

module mtep_decoder (
   input  wire logic          clock,
   input  wire logic          reset,
   input  mtep_pkg::step_type step,
   output logic               res_valid,
   output mtep_pkg::rsp_type  res
);

   logic [2:0]                     phase_ff, phase_in, phase_cur;
   logic [27:0]                    delta_ff, delta_in;
   logic [mtep_pkg::VLQ_CNT_W-1:0] cnt_ff, cnt_in, cnt_cur, cnt_inc;
   logic [7:0]                     rs_ff, rs_in, rs_cur;
   logic [7:0]                     cur_ff, cur_in;
   logic [7:0]                     held_ff, held_in;
   logic [27:0]                    left_ff, left_in;
   logic [7:0]                     b;
   logic [1:0]                     need;
   logic                           emit, err;
   mtep_pkg::rsp_type              r;

   assign b = step.track_byte;

   always_comb begin
      phase_cur = step.track_start ? mtep_pkg::PH_DELTA : phase_ff;
      cnt_cur   = step.track_start ? '0 : cnt_ff;
      rs_cur    = step.track_start ? '0 : rs_ff;
      cnt_inc   = cnt_cur + 1'b1;
      phase_in  = phase_cur;
      cnt_in    = cnt_cur;
      rs_in     = rs_cur;
      delta_in  = delta_ff;
      cur_in    = cur_ff;
      held_in   = held_ff;
      left_in   = left_ff;
      need      = 2'd0;
      emit      = 1'b0;
      err       = 1'b0;
      r         = '0;

      case (phase_cur)
         mtep_pkg::PH_DELTA: begin
            delta_in = {(cnt_cur == '0) ? 21'd0 : delta_ff[20:0], b[6:0]};
            if (!b[7]) begin
               cnt_in   = '0;
               phase_in = mtep_pkg::PH_STATUS;
            end else if (cnt_inc >= mtep_pkg::VLQ_CNT_W'(mtep_pkg::MAX_VLQ_BYTES)) begin
               err = 1'b1;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         mtep_pkg::PH_STATUS: begin
            if (b == mtep_pkg::ST_META) begin
               rs_in    = '0;
               phase_in = mtep_pkg::PH_META_TYPE;
            end else if (b == mtep_pkg::ST_SYSEX) begin
               rs_in    = '0;
               cur_in   = mtep_pkg::ST_SYSEX;
               phase_in = mtep_pkg::PH_SYSEX;
            end else if (!b[7]) begin
               if (rs_cur == '0) begin
                  err = 1'b1;
               end else begin
                  cur_in = rs_cur;
                  need   = mtep_pkg::data_need(rs_cur);
                  if (need == 2'd1) begin
                     emit         = 1'b1;
                     r.data_count = 2'd1;
                     r.data_one   = b;
                  end else begin
                     held_in  = b;
                     phase_in = mtep_pkg::PH_DATA2;
                  end
               end
            end else begin
               need = mtep_pkg::data_need(b);
               if (need == mtep_pkg::NEED_BAD) begin
                  err = 1'b1;
               end else begin
                  cur_in = b;
                  if (b < mtep_pkg::ST_SYSEX) begin
                     rs_in = b;
                  end else if (b < mtep_pkg::ST_REALTIME) begin
                     rs_in = '0;
                  end
                  if (need == 2'd0) begin
                     emit = 1'b1;
                  end else begin
                     phase_in = mtep_pkg::PH_DATA1;
                  end
               end
            end
         end
         mtep_pkg::PH_DATA1: begin
            need = mtep_pkg::data_need(cur_ff);
            if (need == 2'd1) begin
               emit         = 1'b1;
               r.data_count = 2'd1;
               r.data_one   = b;
            end else begin
               held_in  = b;
               phase_in = mtep_pkg::PH_DATA2;
            end
         end
         mtep_pkg::PH_DATA2: begin
            emit         = 1'b1;
            r.data_count = 2'd2;
            r.data_one   = held_ff;
            r.data_two   = b;
         end
         mtep_pkg::PH_META_TYPE: begin
            cur_in   = b;
            cnt_in   = '0;
            phase_in = mtep_pkg::PH_META_LEN;
         end
         mtep_pkg::PH_META_LEN: begin
            left_in = {(cnt_cur == '0) ? 21'd0 : left_ff[20:0], b[6:0]};
            if (!b[7]) begin
               cnt_in = '0;
               if (left_in == '0) begin
                  r.kind        = mtep_pkg::KIND_META;
                  r.status_byte = cur_ff;
                  r.last_of_run = 1'b1;
                  phase_in      = mtep_pkg::PH_DELTA;
               end else begin
                  phase_in = mtep_pkg::PH_META_DATA;
               end
            end else if (cnt_inc >= mtep_pkg::VLQ_CNT_W'(mtep_pkg::MAX_VLQ_BYTES)) begin
               err = 1'b1;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         mtep_pkg::PH_META_DATA: begin
            left_in         = left_ff - 28'd1;
            r.kind          = mtep_pkg::KIND_META;
            r.status_byte   = cur_ff;
            r.payload_byte  = b;
            r.payload_valid = 1'b1;
            r.last_of_run   = (left_in == '0);
            if (left_in == '0) begin
               phase_in = mtep_pkg::PH_DELTA;
            end
         end
         default: begin
            r.kind        = mtep_pkg::KIND_SYSEX;
            r.status_byte = mtep_pkg::ST_SYSEX;
            if (b == mtep_pkg::ST_SYSEX_END) begin
               r.last_of_run = 1'b1;
               phase_in      = mtep_pkg::PH_DELTA;
            end else begin
               r.payload_byte  = b;
               r.payload_valid = 1'b1;
            end
         end
      endcase

      res_valid = step.fire && (emit || err
                  || (phase_cur == mtep_pkg::PH_META_DATA)
                  || (phase_cur == mtep_pkg::PH_SYSEX)
                  || (phase_cur == mtep_pkg::PH_META_LEN && !b[7] && left_in == '0));

      if (emit) begin
         r.kind        = mtep_pkg::KIND_MIDI;
         r.status_byte = cur_in;
         r.last_of_run = 1'b1;
         phase_in      = mtep_pkg::PH_DELTA;
      end
      if (err) begin
         r             = '0;
         r.kind        = mtep_pkg::KIND_ERROR;
         r.status_byte = b;
         r.last_of_run = 1'b1;
         phase_in      = mtep_pkg::PH_DELTA;
         cnt_in        = '0;
         rs_in         = '0;
      end
      r.delta_time = delta_in;
   end

   assign res = r;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mtep_pkg::PH_DELTA;
         delta_ff <= '0;
         cnt_ff   <= '0;
         rs_ff    <= '0;
         cur_ff   <= '0;
         held_ff  <= '0;
         left_ff  <= '0;
      end else if (step.fire) begin
         phase_ff <= phase_in;
         delta_ff <= delta_in;
         cnt_ff   <= cnt_in;
         rs_ff    <= rs_in;
         cur_ff   <= cur_in;
         held_ff  <= held_in;
         left_ff  <= left_in;
      end
   end

   `MTEP_ASSERT_NEXT(a_error_resets, clock, reset, res_valid && res.kind == mtep_pkg::KIND_ERROR, phase_ff == mtep_pkg::PH_DELTA && rs_ff == '0)
   `MTEP_ASSERT_NOW(a_running_is_channel, clock, reset, 1'b1, rs_ff == '0 || (rs_ff[7] && rs_ff[7:4] != 4'hF))
   `MTEP_ASSERT_NOW(a_meta_left_nonzero, clock, reset, phase_ff == mtep_pkg::PH_META_DATA, left_ff != '0)
   `MTEP_ASSERT_NOW(a_vlq_count_bound, clock, reset, 1'b1, cnt_ff < mtep_pkg::VLQ_CNT_W'(mtep_pkg::MAX_VLQ_BYTES))

endmodule

`default_nettype wire

// ----- hdl/mtep_output_stage.sv -----
// Result register driving the response channel.
// Depends on mtep_pkg and mtep_rsp_if.
`default_nettype none

module mtep_output_stage (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         res_valid,
   input  mtep_pkg::rsp_type res,
   output logic              out_free,
   mtep_rsp_if.source        rsp_port
);

   logic              valid_ff, valid_in;
   mtep_pkg::rsp_type data_ff;

   assign out_free = !valid_ff || rsp_port.ready;

   always_comb begin
      valid_in = valid_ff;
      if (res_valid) begin
         valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         data_ff <= res;
      end
   end

   assign rsp_port.valid         = valid_ff;
   assign rsp_port.kind          = data_ff.kind;
   assign rsp_port.delta_time    = data_ff.delta_time;
   assign rsp_port.status_byte   = data_ff.status_byte;
   assign rsp_port.data_count    = data_ff.data_count;
   assign rsp_port.data_one      = data_ff.data_one;
   assign rsp_port.data_two      = data_ff.data_two;
   assign rsp_port.payload_byte  = data_ff.payload_byte;
   assign rsp_port.payload_valid = data_ff.payload_valid;
   assign rsp_port.last_of_run   = data_ff.last_of_run;

endmodule

`default_nettype wire

// ----- hdl/midi_track_event_parser.sv -----
// MIDI track event parser: takes one track byte per beat and emits at most one result
// per byte. Throughput is one byte per cycle while the result sink keeps up; the input
// register and the result register are the only stages; a byte held in the input
// register is decoded combinationally into the result register, which offers the
// result on the response channel. A stalled result register holds the input stage.
// Depends on mtep_pkg, mtep_if, mtep_input_stage, mtep_decoder and mtep_output_stage.
`default_nettype none

module midi_track_event_parser (
   input  wire logic  clock,
   input  wire logic  reset,
   mtep_req_if.sink   req_port,
   mtep_rsp_if.source rsp_port
);

   mtep_pkg::step_type step;
   mtep_pkg::rsp_type  res;
   logic               res_valid;
   logic               out_free;

   mtep_input_stage u_input (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .out_free (out_free),
      .step     (step)
   );

   mtep_decoder u_decoder (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .res_valid (res_valid),
      .res       (res)
   );

   mtep_output_stage u_output (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .out_free  (out_free),
      .rsp_port  (rsp_port)
   );

endmodule

`default_nettype wire
